/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* src/dcpid_pkg.sv */
// ----------------------------------------------------------------------------
// dcpid_pkg
// Types and constants of the dual channel PID controller.
// ----------------------------------------------------------------------------
package dcpid_pkg;

	// default number of links with their own state
	localparam int NUM_LINKS_DEF = 2;

	// field widths
	localparam int POS_W  = 16;
	localparam int GAIN_W = 16;
	localparam int ERR_W  = POS_W + 1;
	localparam int DIFF_W = ERR_W + 1;
	localparam int SUM_W  = 32;
	localparam int P_W    = GAIN_W + ERR_W;
	localparam int I_W    = GAIN_W + SUM_W;
	localparam int D_W    = GAIN_W + DIFF_W;
	localparam int ACC_W  = I_W + 2;
	localparam int FRAC_W = 8;
	localparam int Q_W    = ACC_W - FRAC_W;
	localparam int DRV_W  = 13;
	localparam int CFG_IDX_W = 3;

	// output clamp
	localparam int DRIVE_LIMIT = 4095;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP_LOWER = 3'd0,
		CFG_KI_LOWER = 3'd1,
		CFG_KD_LOWER = 3'd2,
		CFG_KP_UPPER = 3'd3,
		CFG_KI_UPPER = 3'd4,
		CFG_KD_UPPER = 3'd5
	} cfg_reg_t;

	// one gain set, signed Q8.8
	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
	} gain_set_t;

	// error stage result
	typedef struct packed {
		logic signed [ERR_W-1:0]  err;
		logic signed [SUM_W-1:0]  sum;
		logic signed [DIFF_W-1:0] diff;
		gain_set_t                gains;
	} err_stage_t;

	// product stage result
	typedef struct packed {
		logic signed [P_W-1:0] p_term;
		logic signed [I_W-1:0] i_term;
		logic signed [D_W-1:0] d_term;
	} prod_stage_t;

endpackage

/* src/dual_channel_pid_controller_unit.sv */
// ----------------------------------------------------------------------------
// dual_channel_pid_controller_unit
// Two-link discrete PID controller with signed Q8.8 gains.
// ----------------------------------------------------------------------------
// Each input transaction names a link, a setpoint and a measured position and
// returns one drive value, clamped to +/-4095. The unit takes one transaction
// per clock unless the output stream stalls on m_tready; the per-link
// error sum, previous error and last setpoint are read, updated and written in
// the cycle in which a transaction leaves the input register, so
// transactions on the same link may follow back to back. A setpoint that
// differs from the link's last one clears its sum and previous error first.
// The integral saturates at the signed 32-bit range and the scaled sum drops
// its 8 fraction bits toward zero. A link with no state yields a drive of 0.
// The user writes gains on the cfg port only while idle; no check enforces it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_channel_pid_controller_unit #(
	parameter int NUM_LINKS = dcpid_pkg::NUM_LINKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] set_point, [31:16] actual_position
	input  logic [0:0]  s_tuser,   // [0] link_select
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [12:0] drive_value, [15:13] zero
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [dcpid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcpid_pkg::GAIN_W-1:0]    cfg_data
);

	logic                               valid_s1;
	logic                               link_s1;
	logic signed [dcpid_pkg::POS_W-1:0] sp_s1;
	logic signed [dcpid_pkg::POS_W-1:0] pos_s1;

	dcpid_pkg::gain_set_t  gain_lower_q;
	dcpid_pkg::gain_set_t  gain_upper_q;

	logic                  st_ready;
	logic                  err_valid;
	logic                  err_ready;
	dcpid_pkg::err_stage_t err_data;
	logic                  prod_valid;
	logic                  prod_ready;
	dcpid_pkg::prod_stage_t prod_data;
	logic signed [dcpid_pkg::DRV_W-1:0] drive_value;

	// gain registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_lower_q <= '0;
			gain_upper_q <= '0;
		end else if (cfg_valid) begin
			case (dcpid_pkg::cfg_reg_t'(cfg_index))
				dcpid_pkg::CFG_KP_LOWER: gain_lower_q.kp <= cfg_data;
				dcpid_pkg::CFG_KI_LOWER: gain_lower_q.ki <= cfg_data;
				dcpid_pkg::CFG_KD_LOWER: gain_lower_q.kd <= cfg_data;
				dcpid_pkg::CFG_KP_UPPER: gain_upper_q.kp <= cfg_data;
				dcpid_pkg::CFG_KI_UPPER: gain_upper_q.ki <= cfg_data;
				dcpid_pkg::CFG_KD_UPPER: gain_upper_q.kd <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign s_tready = !valid_s1 || st_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			link_s1 <= s_tuser[0];
			sp_s1   <= s_tdata[15:0];
			pos_s1  <= s_tdata[31:16];
		end
	end

	dcpid_state #(
		.NUM_LINKS (NUM_LINKS)
	) u_state (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (valid_s1),
		.in_ready        (st_ready),
		.link            (link_s1),
		.set_point       (sp_s1),
		.actual_position (pos_s1),
		.gain_lower      (gain_lower_q),
		.gain_upper      (gain_upper_q),
		.out_valid       (err_valid),
		.out_ready       (err_ready),
		.out_data        (err_data)
	);

	dcpid_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (err_valid),
		.in_ready  (err_ready),
		.in_data   (err_data),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_data  (prod_data)
	);

	dcpid_drive u_drive (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (prod_valid),
		.in_ready    (prod_ready),
		.in_data     (prod_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.drive_value (drive_value)
	);

	assign m_tdata = {{(16 - dcpid_pkg::DRV_W){1'b0}}, drive_value};

	// an empty input register always takes a transaction
	`ASSERT_PROP(a_empty_takes, clk, arst_n, !valid_s1 |-> s_tready)

endmodule

/* src/dcpid_state.sv */
// ----------------------------------------------------------------------------
// dcpid_state
// Per-link state and error stage: setpoint change detection, error,
// saturating integral and derivative difference, read-modify-write of the state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcpid_state #(
	parameter int NUM_LINKS = dcpid_pkg::NUM_LINKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              link,
	input  logic signed [dcpid_pkg::POS_W-1:0] set_point,
	input  logic signed [dcpid_pkg::POS_W-1:0] actual_position,
	input  dcpid_pkg::gain_set_t              gain_lower,
	input  dcpid_pkg::gain_set_t              gain_upper,
	output logic                              out_valid,
	input  logic                              out_ready,
	output dcpid_pkg::err_stage_t             out_data
);

	logic signed [dcpid_pkg::SUM_W-1:0] sum_q  [NUM_LINKS];
	logic signed [dcpid_pkg::ERR_W-1:0] prev_q [NUM_LINKS];
	logic signed [dcpid_pkg::POS_W-1:0] last_q [NUM_LINKS];

	logic                               valid_s2;
	dcpid_pkg::err_stage_t              data_s2;

	logic                               adv;
	logic [NUM_LINKS-1:0]               hit;
	logic signed [dcpid_pkg::SUM_W-1:0] sum_rd;
	logic signed [dcpid_pkg::ERR_W-1:0] prev_rd;
	logic signed [dcpid_pkg::POS_W-1:0] last_rd;
	logic                               changed;
	logic signed [dcpid_pkg::SUM_W-1:0] sum_base;
	logic signed [dcpid_pkg::ERR_W-1:0] prev_base;
	logic signed [dcpid_pkg::ERR_W-1:0] err;
	logic signed [dcpid_pkg::SUM_W:0]   sum_ext;
	logic signed [dcpid_pkg::SUM_W-1:0] sum_sat;
	logic signed [dcpid_pkg::DIFF_W-1:0] diff;
	dcpid_pkg::err_stage_t              stage_d;

	assign in_ready = !valid_s2 || out_ready;
	assign adv      = in_valid && in_ready;

	// select the addressed link's state
	always_comb begin
		hit     = '0;
		sum_rd  = '0;
		prev_rd = '0;
		last_rd = '0;
		for (int i = 0; i < NUM_LINKS; i++) begin
			if (32'(link) == i) begin
				hit[i]  = 1'b1;
				sum_rd  = sum_q[i];
				prev_rd = prev_q[i];
				last_rd = last_q[i];
			end
		end
	end

	// error, saturating sum and difference
	always_comb begin
		changed   = (set_point != last_rd);
		sum_base  = changed ? '0 : sum_rd;
		prev_base = changed ? '0 : prev_rd;
		err       = $signed({set_point[dcpid_pkg::POS_W-1], set_point})
		          - $signed({actual_position[dcpid_pkg::POS_W-1], actual_position});
		sum_ext   = $signed({sum_base[dcpid_pkg::SUM_W-1], sum_base})
		          + $signed({{(dcpid_pkg::SUM_W + 1 - dcpid_pkg::ERR_W)
		                      {err[dcpid_pkg::ERR_W-1]}}, err});
		if (sum_ext[dcpid_pkg::SUM_W] != sum_ext[dcpid_pkg::SUM_W-1]) begin
			sum_sat = sum_ext[dcpid_pkg::SUM_W] ?
			          {1'b1, {(dcpid_pkg::SUM_W-1){1'b0}}} :
			          {1'b0, {(dcpid_pkg::SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_ext[dcpid_pkg::SUM_W-1:0];
		end
		diff = $signed({err[dcpid_pkg::ERR_W-1], err})
		     - $signed({prev_base[dcpid_pkg::ERR_W-1], prev_base});
	end

	// a link without state gives a zero result
	always_comb begin
		stage_d = '0;
		if (|hit) begin
			stage_d.err   = err;
			stage_d.sum   = sum_sat;
			stage_d.diff  = diff;
			stage_d.gains = link ? gain_upper : gain_lower;
		end
	end

	// per-link state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINKS; i++) begin
				sum_q[i]  <= '0;
				prev_q[i] <= '0;
				last_q[i] <= '0;
			end
		end else if (adv) begin
			for (int i = 0; i < NUM_LINKS; i++) begin
				if (hit[i]) begin
					sum_q[i]  <= sum_sat;
					prev_q[i] <= err;
					last_q[i] <= set_point;
				end
			end
		end
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= stage_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	// link 0 ends a transaction holding its setpoint as the last one
	`ASSERT_PROP(a_last_sp_stored, clk, arst_n, (adv && hit[0]) |=> (last_q[0] == $past(set_point)))
	// link 0 keeps this transaction's error as the previous error
	`ASSERT_PROP(a_prev_err_stored, clk, arst_n, (adv && hit[0]) |=> (prev_q[0] == $past(err)))

endmodule

/* src/dcpid_mult.sv */
// ----------------------------------------------------------------------------
// dcpid_mult
// Product stage: the three gain products of one transaction, registered.
// ----------------------------------------------------------------------------
module dcpid_mult (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  dcpid_pkg::err_stage_t  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output dcpid_pkg::prod_stage_t out_data
);

	logic                   valid_s3;
	dcpid_pkg::prod_stage_t prod_s3;
	dcpid_pkg::prod_stage_t prod_d;

	assign in_ready = !valid_s3 || out_ready;

	// signed products at full width
	always_comb begin
		prod_d.p_term = $signed(in_data.gains.kp) * $signed(in_data.err);
		prod_d.i_term = $signed(in_data.gains.ki) * $signed(in_data.sum);
		prod_d.d_term = $signed(in_data.gains.kd) * $signed(in_data.diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s3 <= prod_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = prod_s3;

endmodule

/* src/dcpid_drive.sv */
// ----------------------------------------------------------------------------
// dcpid_drive
// Output stages: sum of products, drop of the fraction bits toward zero,
// clamp to the drive limit and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcpid_drive (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  dcpid_pkg::prod_stage_t            in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [dcpid_pkg::DRV_W-1:0] drive_value
);

	localparam int AW = dcpid_pkg::ACC_W;
	localparam int QW = dcpid_pkg::Q_W;

	logic                  valid_s4;
	logic signed [AW-1:0]  sum_s4;
	logic                  valid_q;
	logic signed [dcpid_pkg::DRV_W-1:0] drive_q;

	logic                  ready_o;
	logic                  adv_o;
	logic signed [AW-1:0]  sum_d;
	logic signed [QW-1:0]  quot;
	logic                  fix_up;
	logic signed [QW-1:0]  quot_tz;
	logic signed [dcpid_pkg::DRV_W-1:0] drive_d;

	assign ready_o  = !valid_q || out_ready;
	assign in_ready = !valid_s4 || ready_o;
	assign adv_o    = valid_s4 && ready_o;

	// sum of the three terms
	assign sum_d = $signed({{(AW - dcpid_pkg::P_W){in_data.p_term[dcpid_pkg::P_W-1]}},
	                        in_data.p_term})
	             + $signed({{(AW - dcpid_pkg::I_W){in_data.i_term[dcpid_pkg::I_W-1]}},
	                        in_data.i_term})
	             + $signed({{(AW - dcpid_pkg::D_W){in_data.d_term[dcpid_pkg::D_W-1]}},
	                        in_data.d_term});

	// divide by 256 toward zero, then clamp
	always_comb begin
		quot    = sum_s4[AW-1:dcpid_pkg::FRAC_W];
		fix_up  = sum_s4[AW-1] && (|sum_s4[dcpid_pkg::FRAC_W-1:0]);
		quot_tz = quot + $signed(QW'(fix_up));
		if (quot_tz > $signed(QW'(dcpid_pkg::DRIVE_LIMIT))) begin
			drive_d = dcpid_pkg::DRV_W'(dcpid_pkg::DRIVE_LIMIT);
		end else if (quot_tz < -$signed(QW'(dcpid_pkg::DRIVE_LIMIT))) begin
			drive_d = -dcpid_pkg::DRV_W'(dcpid_pkg::DRIVE_LIMIT);
		end else begin
			drive_d = quot_tz[dcpid_pkg::DRV_W-1:0];
		end
	end

	// sum register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s4 <= in_valid;
			end
			if (ready_o) begin
				valid_q <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sum_s4 <= sum_d;
		end
		if (adv_o) begin
			drive_q <= drive_d;
		end
	end

	assign out_valid   = valid_q;
	assign drive_value = drive_q;

	// a non-negative sum never gives a negative drive
	`ASSERT_PROP(a_drive_sign, clk, arst_n, (adv_o && !sum_s4[AW-1]) |=> !drive_q[dcpid_pkg::DRV_W-1])

endmodule
